>>> src/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Shared widths, codes and controller/datapath interface types for the
// telemetry byte averager.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int RAW_W      = 8;
    localparam int SIG_W      = 7;
    localparam int TMP_W      = 6;
    localparam int Q_W        = 16;
    localparam int CH_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SCALE_W    = 11;
    localparam int DEFAULT_LEN = 20;

    // byte classes
    localparam logic [RAW_W-1:0] SIG_LIMIT = 8'd128;
    localparam logic [RAW_W-1:0] TEMP_LO   = 8'd220;
    localparam logic [RAW_W-1:0] TEMP_HI   = 8'd249;
    localparam logic [RAW_W-1:0] TEMP_BIAS = 8'd213;

    // 32 degrees in q8.8
    localparam logic [Q_W-1:0] F_OFFSET = 16'd8192;

    // scale factors as shifts: 256, 640 = 512 + 128, 1152 = 1024 + 128
    localparam int SH_SIG = 8;
    localparam int SH_C   = 9;
    localparam int SH_F   = 10;
    localparam int SH_LOW = 7;

    localparam logic [CH_W-1:0] CH_SIGNAL     = 2'd0;
    localparam logic [CH_W-1:0] CH_CELSIUS    = 2'd1;
    localparam logic [CH_W-1:0] CH_FAHRENHEIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TMP_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAHR    = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
        logic scale;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_hit;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

>>> src/telemetry_byte_averager_top.sv
// ----------------------------------------------------------------------------
// telemetry_byte_averager_top
// Boxcar averaging of signal-level and temperature telemetry bytes.
// ----------------------------------------------------------------------------
// Bytes below 128 feed the signal average (channel 0); bytes 220..249 feed
// the temperature average, reported in Celsius (channel 1) or Fahrenheit
// (channel 2), all as unsigned q8.8. Other bytes are taken while idle and
// give no item. A byte that gives a result goes through the ring read, the
// sum update, the scaling and the divider start, then a restoring divider
// by the window length, one quotient bit per cycle, then a wait for the
// divider to finish, and is then loaded into the output register. The
// next byte can be taken in the cycle after that load, so one averaged
// byte is done before the next byte is taken.
// The next byte can be taken while that result still
// waits at the output. A result that is ready while the one before it still
// waits holds the block until the earlier one is taken. Rings are not
// cleared after reset or a length write: a fill count tracks which entries
// hold real samples, so no start-up pass is needed. Configuration is
// accepted in any cycle and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module telemetry_byte_averager_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tba_pkg::RAW_W-1:0]        raw_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tba_pkg::CH_W-1:0]         channel,
    output logic [tba_pkg::Q_W-1:0]          average_q8,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    tba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tba_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_byte   (raw_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .channel    (channel),
        .average_q8 (average_q8),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

>>> src/tba_ram.sv
// ----------------------------------------------------------------------------
// tba_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tba_div.sv
// ----------------------------------------------------------------------------
// tba_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in Q_W bits, so only the low Q_W dividend bits are iterated.
// ----------------------------------------------------------------------------
module tba_div #(
    parameter int LEN_W = 7,
    parameter int DVD_W = 31
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [LEN_W-1:0]         divisor,
    output logic [tba_pkg::Q_W-1:0]  quotient,
    output logic                     done
);
    import tba_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [LEN_W:0] trial;
    logic [LEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper part is below the divisor since the quotient fits
            rem_next = LEN_W'(dividend >> Q_W);
            quo_next = dividend[Q_W-1:0];
            cnt_next = CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_next  = {quo_reg[Q_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> src/tba_ctrl.sv
// ----------------------------------------------------------------------------
// tba_ctrl
// Sequencer: accept, ring read, sum update, scale, divide, hand off result.
// ----------------------------------------------------------------------------
module tba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tba_pkg::stat_t stat,
    output tba_pkg::cmd_t  cmd
);
    import tba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCALE,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // bytes outside both classes are taken and dropped
                if (in_valid && stat.in_hit)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.upd    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/tba_datapath.sv
// ----------------------------------------------------------------------------
// tba_datapath
// Configuration registers, the two averagers (ring RAM, running sum, write
// position, fill count), scaling, divider and output register.
// ----------------------------------------------------------------------------
module tba_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tba_pkg::RAW_W-1:0]        raw_byte,
    input  logic                             cfg_valid,
    input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [tba_pkg::CH_W-1:0]         channel,
    output logic [tba_pkg::Q_W-1:0]          average_q8,
    input  tba_pkg::cmd_t                    cmd,
    output tba_pkg::stat_t                   stat
);
    import tba_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SIG_W + LEN_W;
    localparam int DVD_W = SUM_W + SCALE_W;
    localparam int RESET_LEN = (MAX_WINDOW < DEFAULT_LEN) ? MAX_WINDOW : DEFAULT_LEN;

    // configuration
    logic [LEN_W-1:0] sig_len_reg, tmp_len_reg;
    logic             fahr_reg;
    logic [LEN_W-1:0] cfg_len;

    // averager state
    logic             sig_primed_reg, tmp_primed_reg;
    logic [POS_W-1:0] sig_pos_reg, tmp_pos_reg;
    logic [LEN_W-1:0] sig_fill_reg, tmp_fill_reg;
    logic [SUM_W-1:0] sig_sum_reg, tmp_sum_reg;
    logic [SIG_W-1:0] sig_prime_reg;
    logic [TMP_W-1:0] tmp_prime_reg;

    // item in flight
    logic [SIG_W-1:0] sample_reg;
    logic             is_temp_reg;
    logic [SUM_W-1:0] sum_new_reg;
    logic [DVD_W-1:0] dividend_reg;
    logic [CH_W-1:0]  chan_reg;

    // output register
    logic             out_valid_reg;
    logic [CH_W-1:0]  out_chan_reg;
    logic [Q_W-1:0]   out_avg_reg;

    logic             in_sig, in_temp;
    logic [RAW_W-1:0] temp_code;

    logic [SIG_W-1:0] sig_rdata;
    logic [TMP_W-1:0] tmp_rdata;

    logic [LEN_W-1:0] cur_len, cur_fill, cur_pos_ext, pos_inc, fill_next;
    logic [POS_W-1:0] cur_pos, pos_next;
    logic [SUM_W-1:0] cur_sum, push_sum, prime_sum, new_sum;
    logic             cur_primed;
    logic [SIG_W-1:0] cur_prime, cur_rdata, old_sample;

    logic [DVD_W-1:0] sum_ext, scaled;
    logic [Q_W-1:0]   quotient;
    logic             div_done;

    // ---------------- classification ----------------
    assign in_sig    = (raw_byte < SIG_LIMIT);
    assign in_temp   = (raw_byte >= TEMP_LO) && (raw_byte <= TEMP_HI);
    assign temp_code = raw_byte - TEMP_BIAS;

    // zero is stored as one, anything above the ring depth as the depth
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (int'(cfg_data) > MAX_WINDOW)
        begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = LEN_W'(cfg_data);
        end
    end

    // ---------------- selected averager ----------------
    assign cur_len     = is_temp_reg ? tmp_len_reg : sig_len_reg;
    assign cur_fill    = is_temp_reg ? tmp_fill_reg : sig_fill_reg;
    assign cur_pos     = is_temp_reg ? tmp_pos_reg : sig_pos_reg;
    assign cur_sum     = is_temp_reg ? tmp_sum_reg : sig_sum_reg;
    assign cur_primed  = is_temp_reg ? tmp_primed_reg : sig_primed_reg;
    assign cur_prime   = is_temp_reg ? SIG_W'(tmp_prime_reg) : sig_prime_reg;
    assign cur_rdata   = is_temp_reg ? SIG_W'(tmp_rdata) : sig_rdata;
    assign cur_pos_ext = LEN_W'(cur_pos);

    // entries not written since priming are read as the priming sample
    assign old_sample = (cur_pos_ext < cur_fill) ? cur_rdata : cur_prime;
    assign push_sum   = cur_sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
    assign prime_sum  = SUM_W'(sample_reg) * SUM_W'(cur_len);
    assign new_sum    = cur_primed ? push_sum : prime_sum;

    assign pos_inc   = cur_pos_ext + 1'b1;
    assign pos_next  = (pos_inc == cur_len) ? '0 : POS_W'(pos_inc);
    assign fill_next = (cur_pos_ext >= cur_fill) ? pos_inc : cur_fill;

    // ---------------- scaling ----------------
    assign sum_ext = DVD_W'(sum_new_reg);
    always_comb
    begin
        if (!is_temp_reg)
        begin
            scaled = sum_ext << SH_SIG;
        end
        else if (fahr_reg)
        begin
            scaled = (sum_ext << SH_F) + (sum_ext << SH_LOW);
        end
        else
        begin
            scaled = (sum_ext << SH_C) + (sum_ext << SH_LOW);
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_len_reg    <= LEN_W'(RESET_LEN);
            tmp_len_reg    <= LEN_W'(RESET_LEN);
            fahr_reg       <= 1'b0;
            sig_primed_reg <= 1'b0;
            tmp_primed_reg <= 1'b0;
            sig_pos_reg    <= '0;
            tmp_pos_reg    <= '0;
            sig_fill_reg   <= '0;
            tmp_fill_reg   <= '0;
            sig_sum_reg    <= '0;
            tmp_sum_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SIG_LEN:
                    begin
                        sig_len_reg    <= cfg_len;
                        sig_primed_reg <= 1'b0;
                    end
                    REG_TMP_LEN:
                    begin
                        tmp_len_reg    <= cfg_len;
                        tmp_primed_reg <= 1'b0;
                    end
                    REG_FAHR:
                    begin
                        fahr_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.upd)
            begin
                if (is_temp_reg)
                begin
                    tmp_primed_reg <= 1'b1;
                    tmp_sum_reg    <= new_sum;
                    tmp_pos_reg    <= cur_primed ? pos_next : '0;
                    tmp_fill_reg   <= cur_primed ? fill_next : '0;
                end
                else
                begin
                    sig_primed_reg <= 1'b1;
                    sig_sum_reg    <= new_sum;
                    sig_pos_reg    <= cur_primed ? pos_next : '0;
                    sig_fill_reg   <= cur_primed ? fill_next : '0;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_temp_reg <= in_temp;
            sample_reg  <= in_temp ? temp_code[SIG_W-1:0] : raw_byte[SIG_W-1:0];
        end
        if (cmd.upd)
        begin
            sum_new_reg <= new_sum;
            if (!cur_primed)
            begin
                if (is_temp_reg)
                begin
                    tmp_prime_reg <= sample_reg[TMP_W-1:0];
                end
                else
                begin
                    sig_prime_reg <= sample_reg;
                end
            end
        end
        if (cmd.scale)
        begin
            dividend_reg <= scaled;
            if (!is_temp_reg)
            begin
                chan_reg <= CH_SIGNAL;
            end
            else
            begin
                chan_reg <= fahr_reg ? CH_FAHRENHEIT : CH_CELSIUS;
            end
        end
        if (cmd.out_load)
        begin
            out_chan_reg <= chan_reg;
            out_avg_reg  <= (chan_reg == CH_FAHRENHEIT) ? quotient + F_OFFSET : quotient;
        end
    end

    // ---------------- ring memories ----------------
    tba_ram #(
        .WIDTH (SIG_W),
        .DEPTH (MAX_WINDOW)
    ) u_sig_ring (
        .clk   (clk),
        .we    (cmd.upd && !is_temp_reg && sig_primed_reg),
        .waddr (sig_pos_reg),
        .wdata (sample_reg),
        .re    (cmd.rd),
        .raddr (sig_pos_reg),
        .rdata (sig_rdata)
    );

    tba_ram #(
        .WIDTH (TMP_W),
        .DEPTH (MAX_WINDOW)
    ) u_tmp_ring (
        .clk   (clk),
        .we    (cmd.upd && is_temp_reg && tmp_primed_reg),
        .waddr (tmp_pos_reg),
        .wdata (sample_reg[TMP_W-1:0]),
        .re    (cmd.rd),
        .raddr (tmp_pos_reg),
        .rdata (tmp_rdata)
    );

    // ---------------- divider ----------------
    tba_div #(
        .LEN_W (LEN_W),
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend_reg),
        .divisor  (cur_len),
        .quotient (quotient),
        .done     (div_done)
    );

    assign stat.in_hit   = in_sig || in_temp;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign channel    = out_chan_reg;
    assign average_q8 = out_avg_reg;

endmodule

>>> tb/telemetry_byte_averager_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_byte_averager_checker
// Passive scoreboard for the telemetry byte averager. It follows register
// writes and accepted bytes, keeps its own copy of both boxcar averagers and
// compares every accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module telemetry_byte_averager_checker #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [tba_pkg::RAW_W-1:0]        raw_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [tba_pkg::CH_W-1:0]         channel,
    input  logic [tba_pkg::Q_W-1:0]          average_q8,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tba_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               checked_count
);

    import tba_pkg::*;

    localparam int UNIT_SIG = 0;
    localparam int UNIT_TMP = 1;

    localparam int unsigned SCALE_SIG = 256;
    localparam int unsigned SCALE_C   = 640;
    localparam int unsigned SCALE_F   = 1152;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [Q_W-1:0]  avg;
    } avg_result_t;

    int unsigned ring [2][MAX_WINDOW];
    int unsigned run_sum [2];
    int unsigned wr_pos [2];
    int unsigned win_len [2];
    logic        primed [2];
    logic        fahrenheit;

    avg_result_t due_results [$];
    avg_result_t oldest;

    function automatic int unsigned clamp_window(input int unsigned v);
        if (v < 1)
            return 1;
        if (v > MAX_WINDOW)
            return MAX_WINDOW;
        return v;
    endfunction

    task automatic clear_state();
        for (int u = 0; u < 2; u++)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                ring[u][i] = 0;
            run_sum[u] = 0;
            wr_pos[u]  = 0;
            win_len[u] = clamp_window(DEFAULT_LEN);
            primed[u]  = 1'b0;
        end
        fahrenheit = 1'b0;
        due_results.delete();
    endtask

    // one sample into a boxcar, gives the running sum afterwards
    function automatic int unsigned push_sample(input int u, input int unsigned s);
        if (!primed[u])
        begin
            // first sample fills the whole window
            primed[u] = 1'b1;
            for (int i = 0; i < win_len[u]; i++)
                ring[u][i] = s;
            run_sum[u] = s * win_len[u];
            wr_pos[u]  = 0;
            return run_sum[u];
        end
        if (wr_pos[u] >= win_len[u])
            wr_pos[u] = 0;
        run_sum[u] = run_sum[u] - ring[u][wr_pos[u]] + s;
        ring[u][wr_pos[u]] = s;
        wr_pos[u] = (wr_pos[u] + 1) % win_len[u];
        return run_sum[u];
    endfunction

    function automatic void predict_average(input logic [RAW_W-1:0] b);
        int unsigned total;
        avg_result_t r;
        if (b < SIG_LIMIT)
        begin
            total = push_sample(UNIT_SIG, int'(b));
            r.ch  = CH_SIGNAL;
            r.avg = Q_W'((total * SCALE_SIG) / win_len[UNIT_SIG]);
            due_results.push_back(r);
        end
        else if (b >= TEMP_LO && b <= TEMP_HI)
        begin
            total = push_sample(UNIT_TMP, int'(b) - int'(TEMP_BIAS));
            if (fahrenheit)
            begin
                r.ch  = CH_FAHRENHEIT;
                r.avg = Q_W'((total * SCALE_F) / win_len[UNIT_TMP] + int'(F_OFFSET));
            end
            else
            begin
                r.ch  = CH_CELSIUS;
                r.avg = Q_W'((total * SCALE_C) / win_len[UNIT_TMP]);
            end
            due_results.push_back(r);
        end
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SIG_LEN:
            begin
                win_len[UNIT_SIG] = clamp_window(int'(data));
                primed[UNIT_SIG]  = 1'b0;
            end
            REG_TMP_LEN:
            begin
                win_len[UNIT_TMP] = clamp_window(int'(data));
                primed[UNIT_TMP]  = 1'b0;
            end
            REG_FAHR:
                fahrenheit = data[0];
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            fail_count    = 0;
            checked_count = 0;
            pending       = 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot be the one leaving
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("item with nothing pending, average_q8", 0, average_q8);
                else
                begin
                    oldest = due_results.pop_front();
                    checked_count++;
                    if (channel !== oldest.ch)
                        report_mismatch("channel", oldest.ch, channel);
                    if (average_q8 !== oldest.avg)
                        report_mismatch("average_q8", oldest.avg, average_q8);
                end
            end
            if (in_valid && in_ready)
                predict_average(raw_byte);
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            pending = due_results.size();
        end
    end

endmodule

>>> tb/telemetry_byte_averager_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_byte_averager_top_test
// Stimulus and verdict for the telemetry byte averager. Directed bytes cover
// the class boundaries, window priming and register corner cases; random
// phases then sweep window lengths and temperature units with bursty input
// and an irregular result stall. Checking is done by the scoreboard module.
// ----------------------------------------------------------------------------
module telemetry_byte_averager_top_test;

    import tba_pkg::*;

    localparam int MAX_WINDOW   = 64;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [RAW_W-1:0]      raw_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CH_W-1:0]       channel;
    logic [Q_W-1:0]        average_q8;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checked_count;

    int result_bytes  = 0;
    int ignored_bytes = 0;
    int reg_writes    = 0;
    int rx_cycle      = 0;

    telemetry_byte_averager_top #(
        .MAX_WINDOW(MAX_WINDOW)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_byte   (raw_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel    (channel),
        .average_q8 (average_q8),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    telemetry_byte_averager_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_byte      (raw_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel       (channel),
        .average_q8    (average_q8),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern: free flow, coin toss, rare ready, fixed duty
    always @(negedge clk)
    begin
        case ((rx_cycle / 300) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((rx_cycle % 7) < 3);
        endcase
        rx_cycle++;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [RAW_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return RAW_W'($urandom_range(0, 127));
        if (roll < 80)
            return RAW_W'($urandom_range(220, 249));
        if (roll < 90)
            return RAW_W'($urandom_range(128, 219));
        return RAW_W'($urandom_range(250, 255));
    endfunction

    // window length values, out-of-range ones included
    function automatic logic [CFG_DATA_W-1:0] choose_len();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd63;
            4:       return 7'd64;
            5:       return CFG_DATA_W'($urandom_range(65, 127));
            default: return CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [RAW_W-1:0] b);
        in_valid <= 1'b1;
        raw_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (b < SIG_LIMIT || (b >= TEMP_LO && b <= TEMP_HI))
            result_bytes++;
        else
            ignored_bytes++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            raw_byte <= RAW_W'($urandom);
            repeat (n) @(negedge clk);
        end
    endtask

    // wait until every result is out, then let a byte in flight finish
    task automatic settle_block();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    initial
    begin
        int phase_results;
        int pause_at;
        int burst;
        int gap;
        logic paused;
        logic steady;
        logic [CFG_IDX_W-1:0] idx;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: first bytes prime both averagers, class boundaries
        send_byte(8'd0);
        send_byte(8'd127);
        send_byte(8'd128);
        send_byte(8'd219);
        send_byte(8'd220);
        send_byte(8'd249);
        send_byte(8'd250);
        send_byte(8'd255);
        send_byte(8'd100);
        send_byte(8'd236);

        settle_block();
        write_reg(REG_FAHR, 7'h01);
        send_byte(8'd249);
        send_byte(8'd220);

        // shortest and longest windows
        settle_block();
        write_reg(REG_SIG_LEN, 7'd1);
        write_reg(REG_TMP_LEN, 7'd64);
        send_byte(8'd127);
        send_byte(8'd0);
        send_byte(8'd5);
        send_byte(8'd230);

        // zero length taken as one, oversize taken as the maximum
        settle_block();
        write_reg(REG_SIG_LEN, 7'd0);
        send_byte(8'd77);
        settle_block();
        write_reg(REG_SIG_LEN, 7'd127);
        send_byte(8'd127);
        send_byte(8'd126);

        // rewriting the same length primes again
        settle_block();
        write_reg(REG_TMP_LEN, 7'd64);
        send_byte(8'd225);

        // only bit 0 of the unit register counts, unknown index ignored
        settle_block();
        write_reg(REG_FAHR, 7'h7E);
        send_byte(8'd240);
        settle_block();
        write_reg(REG_UNUSED, 7'h7F);
        send_byte(8'd10);
        settle_block();
        write_reg(REG_FAHR, 7'h03);
        send_byte(8'd221);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            case (phase)
                0:
                begin
                    write_reg(REG_SIG_LEN, 7'd1);
                    write_reg(REG_TMP_LEN, 7'd1);
                    write_reg(REG_FAHR, 7'h7E);
                end
                1:
                begin
                    write_reg(REG_SIG_LEN, 7'd127);
                    write_reg(REG_TMP_LEN, 7'd64);
                    write_reg(REG_FAHR, 7'h01);
                end
                2:
                begin
                    write_reg(REG_SIG_LEN, 7'd0);
                    write_reg(REG_TMP_LEN, 7'd65);
                    write_reg(REG_FAHR, CFG_DATA_W'($urandom));
                end
                default:
                begin
                    write_reg(REG_SIG_LEN, choose_len());
                    write_reg(REG_TMP_LEN, choose_len());
                    write_reg(REG_FAHR, CFG_DATA_W'($urandom));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

            steady        = (phase % 3 == 2);
            paused        = 1'b0;
            pause_at      = $urandom_range(20, 150);
            phase_results = 0;
            while (phase_results < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    gap = result_bytes;
                    send_byte(pick_byte());
                    phase_results += result_bytes - gap;
                end
                if (steady || $urandom_range(0, 3) == 0)
                    gap = 0;
                else
                    gap = $urandom_range(1, 40);
                idle_cycles(gap);

                // hold the sender until the pipeline is empty, maybe re-prime
                if (!paused && phase_results >= pause_at)
                begin
                    paused = 1'b1;
                    settle_block();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        idx = CFG_IDX_W'($urandom_range(0, 3));
                        if (idx == REG_SIG_LEN || idx == REG_TMP_LEN)
                            write_reg(idx, choose_len());
                        else
                            write_reg(idx, CFG_DATA_W'($urandom));
                    end
                end
            end
        end

        settle_block();

        $display("sent %0d averaged bytes and %0d ignored bytes with %0d register writes",
                 result_bytes, ignored_bytes, reg_writes);
        $display("checked %0d results over windows of 1 to %0d samples in both units",
                 checked_count, MAX_WINDOW);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
src/tba_pkg.sv
src/tba_ram.sv
src/tba_div.sv
src/tba_ctrl.sv
src/tba_datapath.sv
src/telemetry_byte_averager_top.sv
tb/telemetry_byte_averager_checker.sv
tb/telemetry_byte_averager_top_test.sv
